FILE: rtl/mcb_pkg.sv
`timescale 1ns / 1ps

package mcb_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned DimW   = 11;
  localparam int unsigned ColW   = $clog2(MAX_WIDTH);
  localparam int unsigned RowW   = $clog2(MAX_HEIGHT);
  localparam int unsigned VaW    = 8;
  localparam int unsigned SumW   = 30;
  localparam int unsigned TallyW = 20;
  localparam int unsigned FracW  = 8;
  localparam int unsigned CxW    = 18;
  localparam int unsigned BearW  = 16;

  localparam int unsigned ProdW = DimW + TallyW;
  localparam int unsigned MagW  = ProdW + 1;
  localparam int unsigned DvdW  = MagW + VaW + FracW;
  localparam int unsigned DvsW  = ProdW + 1;
  localparam int unsigned CntW  = $clog2(DvdW);

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ANGLE  = 2'd2;

  typedef struct packed {
    logic                    found;
    logic [CxW-1:0]          centroid_x;
    logic signed [BearW-1:0] bearing;
    logic [TallyW-1:0]       hit_count;
  } result_t;

endpackage

FILE: rtl/mask_centroid_bearing.sv
`timescale 1ns / 1ps

// Centroid and bearing of a binary mask, one pixel per request in raster order.
// s_axis carries pixel_set in tdata[0]; the block tracks column and row itself.
// Set pixels in the lower half of the frame add their column to a sum.
// At the last pixel of a frame one result goes out on m_axis: found in tuser,
// centroid_x, bearing and hit_count in tdata (8 fraction bits, toward zero).
// Pixels are taken while the sequencer is idle. After the last pixel of a frame
// tready stays low while the sequencer runs: with a target it does one multiply,
// a difference, a scale, then the shared 48-step restoring divider twice;
// without one it goes straight to the result. The result then moves to the output
// register and the next frame may start while it waits there.
// If the receiver stalls with a result still held, the next frame result
// waits in the sequencer and pixels are held off until the register frees.
// Config writes (width, height, view angle) take effect at once; issue them
// between frames. Reset clears position and sums, loads 320 x 240 and 47 deg.
module mask_centroid_bearing (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] pixel_set
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [17:0] centroid_x, [33:18] bearing,
                                      // [53:34] hit_count
  output logic        m_axis_tuser,   // [0] found
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);

  localparam int unsigned DimW   = mcb_pkg::DimW;
  localparam int unsigned VaW    = mcb_pkg::VaW;
  localparam int unsigned SumW   = mcb_pkg::SumW;
  localparam int unsigned TallyW = mcb_pkg::TallyW;

  logic [DimW-1:0] fw_q, fw_d, fh_q, fh_d, w, h;
  logic [VaW-1:0]  va_q, va_d;

  logic                s_acc, frame_end, calc_idle, res_valid, res_take;
  logic [SumW-1:0]     acc_sum;
  logic [TallyW-1:0]   acc_tally;
  mcb_pkg::result_t    res, out_q, out_d;
  logic                ov_q, ov_d;

  always_comb begin
    fw_d = fw_q;
    fh_d = fh_q;
    va_d = va_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcb_pkg::CFG_WIDTH:  fw_d = cfg_data_i;
        mcb_pkg::CFG_HEIGHT: fh_d = cfg_data_i;
        mcb_pkg::CFG_ANGLE:  va_d = cfg_data_i[VaW-1:0];
        default: ;
      endcase
    end
  end

  assign w = (fw_q == '0) ? DimW'(1) :
             (fw_q > DimW'(mcb_pkg::MAX_WIDTH)) ? DimW'(mcb_pkg::MAX_WIDTH) : fw_q;
  assign h = (fh_q == '0) ? DimW'(1) :
             (fh_q > DimW'(mcb_pkg::MAX_HEIGHT)) ? DimW'(mcb_pkg::MAX_HEIGHT) : fh_q;

  assign s_axis_tready = calc_idle;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  mcb_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (s_acc),
    .pixel_i     (s_axis_tdata[0]),
    .w_i         (w),
    .h_i         (h),
    .frame_end_o (frame_end),
    .sum_o       (acc_sum),
    .tally_o     (acc_tally)
  );

  mcb_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_acc && frame_end),
    .sum_i       (acc_sum),
    .tally_i     (acc_tally),
    .w_i         (w),
    .va_i        (va_q),
    .idle_o      (calc_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_take),
    .res_o       (res)
  );

  assign res_take = res_valid && (!ov_q || m_axis_tready);

  always_comb begin
    ov_d  = ov_q;
    out_d = out_q;
    if (m_axis_tready) begin
      ov_d = 1'b0;
    end
    if (res_take) begin
      ov_d  = 1'b1;
      out_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= DimW'(320);
      fh_q <= DimW'(240);
      va_q <= VaW'(47);
      ov_q <= 1'b0;
    end else begin
      fw_q <= fw_d;
      fh_q <= fh_d;
      va_q <= va_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = {2'b00, out_q.hit_count, out_q.bearing, out_q.centroid_x};

  a_no_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("no-target result carries nonzero fields");

  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[53:34] != '0)
    else $error("found result with zero hit count");

  a_frame_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && frame_end |=> !s_axis_tready)
    else $error("ready after last pixel of frame");

  a_ready_not_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !res_valid)
    else $error("ready while a result is pending");

endmodule

FILE: rtl/mcb_divider.sv
`timescale 1ns / 1ps

module mcb_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mcb_pkg::DvdW-1:0]    dividend_i,
  input  logic [mcb_pkg::DvsW-1:0]    divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [mcb_pkg::DvdW-1:0]    quotient_o
);

  localparam int unsigned DvdW = mcb_pkg::DvdW;
  localparam int unsigned DvsW = mcb_pkg::DvsW;
  localparam int unsigned CntW = mcb_pkg::CntW;

  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvsW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW:0]   trial, diff;
  logic            fit, last;

  assign trial = {rem_q, quo_q[DvdW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fit   = trial >= {1'b0, dvs_q};
  assign last  = cnt_q == CntW'(DvdW - 1);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = busy_q && last;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (last) begin
        busy_d = 1'b0;
      end
      cnt_d = cnt_q + 1'b1;
      rem_d = fit ? diff[DvsW-1:0] : trial[DvsW-1:0];
      quo_d = {quo_q[DvdW-2:0], fit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/mcb_accum.sv
`timescale 1ns / 1ps

module mcb_accum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         pixel_i,
  input  logic [mcb_pkg::DimW-1:0]     w_i,
  input  logic [mcb_pkg::DimW-1:0]     h_i,
  output logic                         frame_end_o,
  output logic [mcb_pkg::SumW-1:0]     sum_o,
  output logic [mcb_pkg::TallyW-1:0]   tally_o
);

  localparam int unsigned DimW   = mcb_pkg::DimW;
  localparam int unsigned ColW   = mcb_pkg::ColW;
  localparam int unsigned RowW   = mcb_pkg::RowW;
  localparam int unsigned SumW   = mcb_pkg::SumW;
  localparam int unsigned TallyW = mcb_pkg::TallyW;

  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [SumW-1:0]   sum_q, sum_d, sum_nx;
  logic [TallyW-1:0] tally_q, tally_d, tally_nx;
  logic [SumW:0]     ns;
  logic              row_end, frame_end, hit;

  assign row_end   = DimW'(col_q) >= (w_i - 1'b1);
  assign frame_end = row_end && (DimW'(row_q) >= (h_i - 1'b1));
  assign ns        = {1'b0, sum_q} + (SumW + 1)'(col_q);
  assign hit       = pixel_i && (DimW'(row_q) >= (h_i >> 1)) &&
                     (tally_q != '1) && !ns[SumW];
  assign sum_nx    = hit ? ns[SumW-1:0] : sum_q;
  assign tally_nx  = hit ? tally_q + 1'b1 : tally_q;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    sum_d   = sum_q;
    tally_d = tally_q;
    if (accept_i) begin
      col_d   = row_end ? '0 : col_q + 1'b1;
      row_d   = frame_end ? '0 : (row_end ? row_q + 1'b1 : row_q);
      sum_d   = frame_end ? '0 : sum_nx;
      tally_d = frame_end ? '0 : tally_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sum_q   <= '0;
      tally_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sum_q   <= sum_d;
      tally_q <= tally_d;
    end
  end

  assign frame_end_o = frame_end;
  assign sum_o       = sum_nx;
  assign tally_o     = tally_nx;

endmodule

FILE: rtl/mcb_calc.sv
`timescale 1ns / 1ps

module mcb_calc (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mcb_pkg::SumW-1:0]     sum_i,
  input  logic [mcb_pkg::TallyW-1:0]   tally_i,
  input  logic [mcb_pkg::DimW-1:0]     w_i,
  input  logic [mcb_pkg::VaW-1:0]      va_i,
  output logic                         idle_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output mcb_pkg::result_t             res_o
);

  localparam int unsigned SumW   = mcb_pkg::SumW;
  localparam int unsigned TallyW = mcb_pkg::TallyW;
  localparam int unsigned FracW  = mcb_pkg::FracW;
  localparam int unsigned CxW    = mcb_pkg::CxW;
  localparam int unsigned BearW  = mcb_pkg::BearW;
  localparam int unsigned ProdW  = mcb_pkg::ProdW;
  localparam int unsigned MagW   = mcb_pkg::MagW;
  localparam int unsigned VaW    = mcb_pkg::VaW;
  localparam int unsigned DvdW   = mcb_pkg::DvdW;
  localparam int unsigned DvsW   = mcb_pkg::DvsW;
  localparam int unsigned DiffW  = ProdW + 2;
  localparam int unsigned SclW   = MagW + VaW;
  localparam logic [DvdW-1:0] PosLim = DvdW'((1 << (BearW - 1)) - 1);
  localparam logic [DvdW-1:0] NegLim = DvdW'(1 << (BearW - 1));

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_DIFF  = 9'b000000100,
    S_SCALE = 9'b000001000,
    S_DIVC  = 9'b000010000,
    S_WAITC = 9'b000100000,
    S_DIVB  = 9'b001000000,
    S_WAITB = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [SumW-1:0]         sum_q, sum_d;
  logic [TallyW-1:0]       tally_q, tally_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic [MagW-1:0]         mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic [DvdW-1:0]         dvd_q, dvd_d;
  logic [CxW-1:0]          cx_q, cx_d;
  logic signed [BearW-1:0] bear_q, bear_d;

  logic signed [DiffW-1:0] diff;
  logic [SclW-1:0]         scaled;
  logic                    div_start, div_busy, div_done;
  logic [DvdW-1:0]         div_dvd, div_q;
  logic [DvsW-1:0]         div_dvs;

  assign diff   = $signed({2'b00, sum_q, 1'b0}) - $signed({2'b00, prod_q});
  assign scaled = SclW'(mag_q) * SclW'(va_i);

  assign div_start = (state_q == S_DIVC) || (state_q == S_DIVB);
  assign div_dvd   = (state_q == S_DIVC) ?
                     {{(DvdW - SumW - FracW){1'b0}}, sum_q, {FracW{1'b0}}} : dvd_q;
  assign div_dvs   = (state_q == S_DIVC) ?
                     {{(DvsW - TallyW){1'b0}}, tally_q} : {prod_q, 1'b0};

  mcb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    tally_d = tally_q;
    prod_d  = prod_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    dvd_d   = dvd_q;
    cx_d    = cx_q;
    bear_d  = bear_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          sum_d   = sum_i;
          tally_d = tally_i;
          cx_d    = '0;
          bear_d  = '0;
          state_d = (tally_i == '0) ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = ProdW'(w_i) * ProdW'(tally_q);
        state_d = S_DIFF;
      end
      S_DIFF: begin
        neg_d   = diff[DiffW-1];
        mag_d   = diff[DiffW-1] ? MagW'(-diff) : MagW'(diff);
        state_d = S_SCALE;
      end
      S_SCALE: begin
        dvd_d   = {scaled, {FracW{1'b0}}};
        state_d = S_DIVC;
      end
      S_DIVC: state_d = S_WAITC;
      S_WAITC: begin
        if (div_done) begin
          cx_d    = div_q[CxW-1:0];
          state_d = S_DIVB;
        end
      end
      S_DIVB: state_d = S_WAITB;
      S_WAITB: begin
        if (div_done) begin
          if (!neg_q) begin
            bear_d = (div_q > PosLim) ? $signed(PosLim[BearW-1:0]) :
                                        $signed(div_q[BearW-1:0]);
          end else begin
            bear_d = (div_q > NegLim) ? $signed(NegLim[BearW-1:0]) :
                                        $signed(-div_q[BearW-1:0]);
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    tally_q <= tally_d;
    prod_q  <= prod_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    dvd_q   <= dvd_d;
    cx_q    <= cx_d;
    bear_q  <= bear_d;
  end

  assign idle_o           = (state_q == S_IDLE) && !div_busy;
  assign res_valid_o      = state_q == S_DONE;
  assign res_o.found      = tally_q != '0;
  assign res_o.centroid_x = cx_q;
  assign res_o.bearing    = bear_q;
  assign res_o.hit_count  = tally_q;

endmodule

FILE: dv/tb_mask_centroid_bearing.sv
`timescale 1ns / 1ps

module tb_mask_centroid_bearing;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] pixel_set
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // [17:0] centroid_x, [33:18] bearing, [53:34] hit_count
  logic        m_axis_tuser;        // [0] found
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;

  mask_centroid_bearing u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the block's registers and frame accumulators
  logic [10:0]     reg_width  = 11'd320;
  logic [10:0]     reg_height = 11'd240;
  logic [7:0]      reg_angle  = 8'd47;
  int unsigned     col_at, row_at;
  longint unsigned col_total, lit_total;

  bit                  pix_q[$];
  mcb_pkg::result_t    frame_q[$];
  int unsigned         frames_due, pix_pushed, errors;
  bit                  calm;

  function automatic int unsigned fit_dim(logic [10:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_len();
    return fit_dim(reg_width, mcb_pkg::MAX_WIDTH) * fit_dim(reg_height, mcb_pkg::MAX_HEIGHT);
  endfunction

  function automatic void track_pixel(bit lit);
    int unsigned      w, h;
    bit               row_done, frame_done;
    longint unsigned  cand;
    longint           num, den, b;
    mcb_pkg::result_t r;
    w = fit_dim(reg_width, mcb_pkg::MAX_WIDTH);
    h = fit_dim(reg_height, mcb_pkg::MAX_HEIGHT);
    row_done = col_at >= w - 1;
    frame_done = row_done && row_at >= h - 1;
    if (lit && row_at >= h / 2) begin
      cand = col_total + col_at;
      if (lit_total + 1 <= 64'hFFFFF && cand <= 64'h3FFF_FFFF) begin
        col_total = cand;
        lit_total++;
      end
    end
    if (row_done) begin
      col_at = 0;
      row_at++;
    end else begin
      col_at++;
    end
    if (frame_done) begin
      row_at = 0;
      r = '0;
      if (lit_total != 0) begin
        num = (2 * longint'(col_total) - longint'(w) * longint'(lit_total))
              * longint'(reg_angle) * 256;
        den = 2 * longint'(lit_total) * longint'(w);
        b = num / den;
        if (b > 32767) b = 32767;
        if (b < -32768) b = -32768;
        r.found      = 1'b1;
        r.centroid_x = mcb_pkg::CxW'((col_total << 8) / lit_total);
        r.bearing    = mcb_pkg::BearW'(b);
        r.hit_count  = mcb_pkg::TallyW'(lit_total);
      end
      frame_q.push_back(r);
      frames_due++;
      col_total = 0;
      lit_total = 0;
    end
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_pixel(s_axis_tdata[0]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pix_q.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, pix_q.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    mcb_pkg::result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_q.size() == 0) begin
          note_error($sformatf("result with none due: tdata %h found %b",
                               m_axis_tdata, m_axis_tuser));
        end else begin
          want = frame_q.pop_front();
          if (m_axis_tuser !== want.found || m_axis_tdata[17:0] !== want.centroid_x ||
              m_axis_tdata[33:18] !== want.bearing ||
              m_axis_tdata[53:34] !== want.hit_count)
            note_error($sformatf(
              "found %b/%b cx %0d/%0d bearing %0d/%0d hits %0d/%0d (exp/got)",
              want.found, m_axis_tuser, want.centroid_x, m_axis_tdata[17:0],
              want.bearing, $signed(m_axis_tdata[33:18]),
              want.hit_count, m_axis_tdata[53:34]));
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mcb_pkg::CFG_WIDTH:  reg_width = val;
      mcb_pkg::CFG_HEIGHT: reg_height = val;
      mcb_pkg::CFG_ANGLE:  reg_angle = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // all pixels taken and every frame result back, then let the block go quiet
  task automatic settle();
    do @(negedge clk_i);
    while (pix_q.size() != 0 || s_axis_tvalid || frame_q.size() != 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic queue_pixels(int unsigned n, int unsigned pct);
    for (int unsigned i = 0; i < n; i++) pix_q.push_back($urandom_range(99) < pct);
    pix_pushed += n;
  endtask

  initial begin
    int unsigned phase, nfr, pct, ang;
    logic [10:0] ang_word;
    bit          big;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 4x2, reset view angle; top row ignored
    write_reg(mcb_pkg::CFG_WIDTH, 11'd4);
    write_reg(mcb_pkg::CFG_HEIGHT, 11'd2);
    pix_q = '{1, 1, 1, 1, 1, 0, 1, 1};
    settle();

    // zero dims act as 1x1, zero angle
    write_reg(mcb_pkg::CFG_WIDTH, 11'd0);
    write_reg(mcb_pkg::CFG_HEIGHT, 11'd0);
    write_reg(mcb_pkg::CFG_ANGLE, 11'd0);
    pix_q = '{1, 0};
    settle();

    // upper data bits ignored for the angle: 180 deg
    write_reg(mcb_pkg::CFG_ANGLE, 11'h7B4);
    pix_q = '{1};
    settle();

    write_reg(mcb_pkg::CFG_WIDTH, 11'd2);
    write_reg(mcb_pkg::CFG_ANGLE, 11'd255);
    pix_q = '{1, 0};
    settle();

    // shrink the frame mid-way: position already past the new end
    write_reg(mcb_pkg::CFG_WIDTH, 11'd8);
    write_reg(mcb_pkg::CFG_HEIGHT, 11'd4);
    queue_pixels(10, 50);
    settle();
    write_reg(mcb_pkg::CFG_WIDTH, 11'd2);
    write_reg(mcb_pkg::CFG_HEIGHT, 11'd2);
    pix_q = '{1};
    settle();

    phase = 0;
    while (pix_pushed < 400 || frames_due < 30 || phase < 12) begin
      calm = (phase >= 3 && phase <= 5);
      big = 1'b0;
      nfr = 0;
      if (phase == 5 || phase == 11) begin
        write_reg(mcb_pkg::CFG_WIDTH, phase == 5 ? 11'h7FF : 11'd1024);
        write_reg(mcb_pkg::CFG_HEIGHT, 11'd1);
        big = 1'b1;
      end else if (phase == 8) begin
        write_reg(mcb_pkg::CFG_WIDTH, 11'd1);
        write_reg(mcb_pkg::CFG_HEIGHT, 11'h7FF);
        big = 1'b1;
      end else begin
        write_reg(mcb_pkg::CFG_WIDTH, 11'($urandom_range(8, 0)));
        write_reg(mcb_pkg::CFG_HEIGHT, 11'($urandom_range(6, 0)));
        nfr = $urandom_range(4, 1);
      end
      case ($urandom_range(5))
        0: ang = 0;
        1: ang = 255;
        2: ang = 180;
        default: ang = $urandom_range(255, 1);
      endcase
      ang_word = {3'($urandom), 8'(ang)};
      write_reg(mcb_pkg::CFG_ANGLE, ang_word);
      if (big) begin
        // oversized frame: only a stretch of it, the next register change ends it
        queue_pixels(24, 50);
      end else begin
        for (int unsigned f = 0; f < nfr; f++) begin
          case ($urandom_range(5))
            0: pct = 0;
            1: pct = 100;
            2: pct = 8;
            3: pct = 92;
            default: pct = $urandom_range(100);
          endcase
          queue_pixels(frame_len(), pct);
        end
        // partial frame: next register change lands mid-frame
        if (frame_len() > 1 && $urandom_range(99) < 15)
          queue_pixels($urandom_range(frame_len() - 1, 1), 50);
      end
      settle();
      phase++;
    end
    calm = 1'b0;

    settle();
    repeat (150) @(posedge clk_i);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("tb_mask_centroid_bearing: clean");
    end else begin
      $display("tb_mask_centroid_bearing: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_mask_centroid_bearing: errors");
    $finish;
  end

endmodule
